// ----- hdl/tkqb_pkg.sv -----
// shared types, widths and codes for the top-k quality buffer
package tkqb_pkg;

   // field widths fixed by the interface
   localparam int BOX_BITS       = 12;
   localparam int QUALITY_BITS   = 24;
   localparam int PORT_TAG_BITS  = 32;
   localparam int KEEP_BITS      = 5;
   localparam int COUNT_BITS     = 5;

   // parameter defaults
   localparam int MAX_ENTRIES_DEF = 16;
   localparam int TAG_BITS_DEF    = 32;

   // keep_count after reset
   localparam logic [KEEP_BITS-1:0] KEEP_RESET = 5'd4;

   // request function codes
   localparam logic FUNC_OFFER = 1'b0;
   localparam logic FUNC_TAKE  = 1'b1;

   // running result of a scan wave: extra top bit marks "none yet"
   typedef struct packed {
      logic                    seen;
      logic [QUALITY_BITS:0]   min_q;
      logic [QUALITY_BITS:0]   second_q;
      logic [QUALITY_BITS-1:0] max_q;
   } sweep_type;

   // per-cell control from the sequencer
   typedef struct packed {
      logic active;
      logic load;
      logic shift;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SWEEP,
      ST_APPLY
   } state_type;

endpackage

// ----- hdl/top_k_quality_buffer.sv -----
// top level: request sequencer, chain of entry cells and response register
//
//  port group   dir   handshake              payload
//  req_*        in    req_valid / req_stall  func, box_width, box_height, frame_tag
//  rsp_*        out   rsp_valid / rsp_stall  entry_valid/tag/quality, offer_stored, held_count
//  csr_*        in    csr_write_en           csr_write_data (keep_count)
//
// appends, drops and takes from an empty buffer: the response is committed from the decide
// state and registered; the next request is accepted once the sequencer is back in idle.
// replacements and other takes: the response is committed from the apply state once the
// scan wave has walked the chain, one cell per cycle; a stalled response holds the commit.
// reset clears the held count, lowest quality and sets keep_count to 4; no clear pass.
// one request is in work at a time; the next is accepted while a response waits.
module top_k_quality_buffer #(
   parameter int MAX_ENTRIES = tkqb_pkg::MAX_ENTRIES_DEF,
   parameter int TAG_BITS    = tkqb_pkg::TAG_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_func,
   input  logic [tkqb_pkg::BOX_BITS-1:0]         req_box_width,
   input  logic [tkqb_pkg::BOX_BITS-1:0]         req_box_height,
   input  logic [tkqb_pkg::PORT_TAG_BITS-1:0]    req_frame_tag,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_entry_valid,
   output logic [tkqb_pkg::PORT_TAG_BITS-1:0]    rsp_entry_tag,
   output logic [tkqb_pkg::QUALITY_BITS-1:0]     rsp_entry_quality,
   output logic                                  rsp_offer_stored,
   output logic [tkqb_pkg::COUNT_BITS-1:0]       rsp_held_count,
   input  logic                                  csr_write_en,
   input  logic [tkqb_pkg::KEEP_BITS-1:0]        csr_write_data
);
   import tkqb_pkg::*;

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int EXT_W = CNT_W + KEEP_BITS;

   state_type state_ff, state_in;

   // request and buffer registers
   logic                    func_ff;
   logic [QUALITY_BITS-1:0] quality_ff;
   logic [TAG_BITS-1:0]     tag_ff;
   logic [CNT_W-1:0]        held_ff, held_in;
   logic [QUALITY_BITS-1:0] lowest_ff, lowest_in;
   logic [KEEP_BITS-1:0]    keep_ff;

   // response register
   logic                     rsp_valid_ff;
   logic                     rsp_entry_valid_ff, rsp_entry_valid_in;
   logic [PORT_TAG_BITS-1:0] rsp_entry_tag_ff, rsp_entry_tag_in;
   logic [QUALITY_BITS-1:0]  rsp_entry_quality_ff, rsp_entry_quality_in;
   logic                     rsp_offer_stored_ff, rsp_offer_stored_in;
   logic [COUNT_BITS-1:0]    rsp_held_count_ff, rsp_held_count_in;

   // chain wiring
   cell_ctrl_type           cell_ctrl [MAX_ENTRIES];
   logic [QUALITY_BITS-1:0] cell_quality [MAX_ENTRIES];
   logic [TAG_BITS-1:0]     cell_tag [MAX_ENTRIES];
   logic [QUALITY_BITS-1:0] next_quality [MAX_ENTRIES];
   logic [TAG_BITS-1:0]     next_tag [MAX_ENTRIES];
   logic                    wave_go [MAX_ENTRIES+1];
   sweep_type               wave [MAX_ENTRIES+1];
   logic [IDX_W-1:0]        wave_min_pos [MAX_ENTRIES+1];
   logic [IDX_W-1:0]        wave_max_pos [MAX_ENTRIES+1];
   logic [TAG_BITS-1:0]     wave_max_tag [MAX_ENTRIES+1];

   // decode and control
   logic                    accept;
   logic                    rsp_free;
   logic                    is_take, take_empty, append_ok, drop, fast;
   logic                    sweep_go, sweep_done, commit;
   logic                    do_load, do_shift, replace;
   logic [IDX_W-1:0]        load_idx;
   logic [EXT_W-1:0]        held_ext, keep_ext;
   logic [QUALITY_BITS-1:0] req_quality;
   logic [TAG_BITS+PORT_TAG_BITS-1:0] in_tag_wide, out_tag_wide;
   logic [CNT_W+COUNT_BITS-1:0]       held_wide;
   sweep_type               last;

   assign accept   = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // area kept in QUALITY_BITS, tag kept in TAG_BITS
   assign req_quality = QUALITY_BITS'(req_box_width) * QUALITY_BITS'(req_box_height);
   assign in_tag_wide = {{TAG_BITS{1'b0}}, req_frame_tag};

   // decision for the held request
   assign held_ext   = {{KEEP_BITS{1'b0}}, held_ff};
   assign keep_ext   = {{CNT_W{1'b0}}, keep_ff};
   assign is_take    = (func_ff == FUNC_TAKE);
   assign take_empty = is_take && (held_ff == '0);
   assign append_ok  = !is_take && (held_ff < CNT_W'(MAX_ENTRIES))
                       && ((held_ext < keep_ext) || (held_ff == '0));
   assign drop       = !is_take && !append_ok && (quality_ff < lowest_ff);
   assign fast       = take_empty || append_ok || drop;

   assign last       = wave[MAX_ENTRIES];
   assign sweep_done = wave_go[MAX_ENTRIES];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (!fast) state_in = ST_SWEEP;
            else if (rsp_free) state_in = ST_IDLE;
         end
         ST_SWEEP:  if (sweep_done) state_in = ST_APPLY;
         ST_APPLY:  if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall = 1'b1;
      sweep_go  = 1'b0;
      commit    = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_stall = 1'b0;
         ST_DECIDE: begin
            sweep_go = !fast;
            commit   = fast && rsp_free;
         end
         ST_SWEEP:  ;
         ST_APPLY:  commit = rsp_free;
         default:   ;
      endcase
   end

   // commit effects on the buffer and the response
   always_comb begin
      do_load              = 1'b0;
      do_shift             = 1'b0;
      replace              = 1'b0;
      load_idx             = wave_min_pos[MAX_ENTRIES];
      held_in              = held_ff;
      lowest_in            = lowest_ff;
      out_tag_wide         = {{PORT_TAG_BITS{1'b0}}, wave_max_tag[MAX_ENTRIES]};
      rsp_entry_valid_in   = 1'b0;
      rsp_entry_tag_in     = '0;
      rsp_entry_quality_in = '0;
      rsp_offer_stored_in  = 1'b0;
      if (commit) begin
         if (state_ff == ST_DECIDE) begin
            if (append_ok) begin
               do_load             = 1'b1;
               load_idx            = held_ff[IDX_W-1:0];
               held_in             = held_ff + 1'b1;
               rsp_offer_stored_in = 1'b1;
            end
         end else if (is_take) begin
            do_shift             = 1'b1;
            held_in              = held_ff - 1'b1;
            rsp_entry_valid_in   = 1'b1;
            rsp_entry_tag_in     = out_tag_wide[PORT_TAG_BITS-1:0];
            rsp_entry_quality_in = last.max_q;
         end else begin
            replace = (last.min_q[QUALITY_BITS-1:0] < quality_ff);
            if (replace) begin
               do_load             = 1'b1;
               rsp_offer_stored_in = 1'b1;
               lowest_in = (last.second_q < {1'b0, quality_ff}) ?
                           last.second_q[QUALITY_BITS-1:0] : quality_ff;
            end else begin
               lowest_in = last.min_q[QUALITY_BITS-1:0];
            end
         end
      end
      held_wide         = {{COUNT_BITS{1'b0}}, held_in};
      rsp_held_count_in = held_wide[COUNT_BITS-1:0];
   end

   // per-cell control
   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         cell_ctrl[i].active = (CNT_W'(i) < held_ff);
         cell_ctrl[i].load   = do_load && (IDX_W'(i) == load_idx);
         cell_ctrl[i].shift  = do_shift && (IDX_W'(i) >= wave_max_pos[MAX_ENTRIES])
                               && (CNT_W'(i + 1) < held_ff);
      end
   end

   // wave entry point
   assign wave_go[0]          = sweep_go;
   assign wave[0].seen        = 1'b0;
   assign wave[0].min_q       = '1;
   assign wave[0].second_q    = '1;
   assign wave[0].max_q       = '0;
   assign wave_min_pos[0]     = '0;
   assign wave_max_pos[0]     = '0;
   assign wave_max_tag[0]     = '0;

   // chain of cells
   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      if (g < MAX_ENTRIES - 1) begin : g_mid
         assign next_quality[g] = cell_quality[g+1];
         assign next_tag[g]     = cell_tag[g+1];
      end else begin : g_end
         assign next_quality[g] = '0;
         assign next_tag[g]     = '0;
      end

      tkqb_cell #(
         .MAX_ENTRIES (MAX_ENTRIES),
         .TAG_BITS    (TAG_BITS)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .cell_index   (IDX_W'(g)),
         .ctrl         (cell_ctrl[g]),
         .load_quality (quality_ff),
         .load_tag     (tag_ff),
         .next_quality (next_quality[g]),
         .next_tag     (next_tag[g]),
         .quality      (cell_quality[g]),
         .tag          (cell_tag[g]),
         .go_in        (wave_go[g]),
         .sweep_in     (wave[g]),
         .min_pos_in   (wave_min_pos[g]),
         .max_pos_in   (wave_max_pos[g]),
         .max_tag_in   (wave_max_tag[g]),
         .go_out       (wave_go[g+1]),
         .sweep_out    (wave[g+1]),
         .min_pos_out  (wave_min_pos[g+1]),
         .max_pos_out  (wave_max_pos[g+1]),
         .max_tag_out  (wave_max_tag[g+1])
      );
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ff      <= '0;
         lowest_ff    <= '0;
         keep_ff      <= KEEP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         held_ff   <= held_in;
         lowest_ff <= lowest_in;
         if (csr_write_en) keep_ff <= csr_write_data;
         if (commit) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff    <= req_func;
         quality_ff <= req_quality;
         tag_ff     <= in_tag_wide[TAG_BITS-1:0];
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_entry_valid_ff   <= rsp_entry_valid_in;
         rsp_entry_tag_ff     <= rsp_entry_tag_in;
         rsp_entry_quality_ff <= rsp_entry_quality_in;
         rsp_offer_stored_ff  <= rsp_offer_stored_in;
         rsp_held_count_ff    <= rsp_held_count_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_entry_valid   = rsp_entry_valid_ff;
   assign rsp_entry_tag     = rsp_entry_tag_ff;
   assign rsp_entry_quality = rsp_entry_quality_ff;
   assign rsp_offer_stored  = rsp_offer_stored_ff;
   assign rsp_held_count    = rsp_held_count_ff;

`ifndef NO_ASSERTIONS
   // the buffer never holds more than its capacity
   assert property (@(posedge clock) disable iff (reset)
      held_ff <= CNT_W'(MAX_ENTRIES))
      else $error("held count above capacity");

   // a response is never committed over one that is still stalled
   assert property (@(posedge clock) disable iff (reset)
      !(commit && rsp_valid_ff && rsp_stall))
      else $error("response overwritten while stalled");

   // the scan wave only leaves the chain while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      sweep_done |-> state_ff == ST_SWEEP)
      else $error("scan result outside sweep state");

   // a successful take removes exactly one entry
   assert property (@(posedge clock) disable iff (reset)
      (commit && state_ff == ST_APPLY && is_take) |=> held_ff == $past(held_ff) - 1'b1)
      else $error("take did not remove one entry");
`endif

endmodule

// ----- hdl/tkqb_cell.sv -----
// one entry of the buffer plus one stage of the min/max scan wave
module tkqb_cell #(
   parameter int MAX_ENTRIES = tkqb_pkg::MAX_ENTRIES_DEF,
   parameter int TAG_BITS    = tkqb_pkg::TAG_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [$clog2(MAX_ENTRIES)-1:0]        cell_index,
   input  tkqb_pkg::cell_ctrl_type               ctrl,
   input  logic [tkqb_pkg::QUALITY_BITS-1:0]     load_quality,
   input  logic [TAG_BITS-1:0]                   load_tag,
   input  logic [tkqb_pkg::QUALITY_BITS-1:0]     next_quality,
   input  logic [TAG_BITS-1:0]                   next_tag,
   output logic [tkqb_pkg::QUALITY_BITS-1:0]     quality,
   output logic [TAG_BITS-1:0]                   tag,
   input  logic                                  go_in,
   input  tkqb_pkg::sweep_type                   sweep_in,
   input  logic [$clog2(MAX_ENTRIES)-1:0]        min_pos_in,
   input  logic [$clog2(MAX_ENTRIES)-1:0]        max_pos_in,
   input  logic [TAG_BITS-1:0]                   max_tag_in,
   output logic                                  go_out,
   output tkqb_pkg::sweep_type                   sweep_out,
   output logic [$clog2(MAX_ENTRIES)-1:0]        min_pos_out,
   output logic [$clog2(MAX_ENTRIES)-1:0]        max_pos_out,
   output logic [TAG_BITS-1:0]                   max_tag_out
);
   import tkqb_pkg::*;

   localparam int IDX_W = $clog2(MAX_ENTRIES);

   logic [QUALITY_BITS-1:0] quality_ff, quality_in;
   logic [TAG_BITS-1:0]     tag_ff, tag_in;
   logic                    go_ff;
   sweep_type               sweep_ff, sweep_in_c;
   logic [IDX_W-1:0]        min_pos_ff, min_pos_in_c;
   logic [IDX_W-1:0]        max_pos_ff, max_pos_in_c;
   logic [TAG_BITS-1:0]     max_tag_ff, max_tag_in_c;
   logic [QUALITY_BITS:0]   own_q;

   // entry update: load a new box, pull from the right neighbor, or hold
   always_comb begin
      quality_in = quality_ff;
      tag_in     = tag_ff;
      if (ctrl.load) begin
         quality_in = load_quality;
         tag_in     = load_tag;
      end else if (ctrl.shift) begin
         quality_in = next_quality;
         tag_in     = next_tag;
      end
   end

   // fold this entry into the passing wave, earliest position wins ties
   always_comb begin
      own_q        = {1'b0, quality_ff};
      sweep_in_c   = sweep_in;
      min_pos_in_c = min_pos_in;
      max_pos_in_c = max_pos_in;
      max_tag_in_c = max_tag_in;
      if (ctrl.active) begin
         if (!sweep_in.seen || own_q < sweep_in.min_q) begin
            sweep_in_c.second_q = sweep_in.min_q;
            sweep_in_c.min_q    = own_q;
            min_pos_in_c        = cell_index;
         end else if (own_q < sweep_in.second_q) begin
            sweep_in_c.second_q = own_q;
         end
         if (!sweep_in.seen || quality_ff > sweep_in.max_q) begin
            sweep_in_c.max_q = quality_ff;
            max_pos_in_c     = cell_index;
            max_tag_in_c     = tag_ff;
         end
         sweep_in_c.seen = 1'b1;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      quality_ff <= quality_in;
      tag_ff     <= tag_in;
   end

   // wave marker
   always_ff @(posedge clock) begin
      if (reset) begin
         go_ff <= 1'b0;
      end else begin
         go_ff <= go_in;
      end
   end

   // wave payload, held once the wave has passed
   always_ff @(posedge clock) begin
      if (go_in) begin
         sweep_ff   <= sweep_in_c;
         min_pos_ff <= min_pos_in_c;
         max_pos_ff <= max_pos_in_c;
         max_tag_ff <= max_tag_in_c;
      end
   end

   assign quality     = quality_ff;
   assign tag         = tag_ff;
   assign go_out      = go_ff;
   assign sweep_out   = sweep_ff;
   assign min_pos_out = min_pos_ff;
   assign max_pos_out = max_pos_ff;
   assign max_tag_out = max_tag_ff;

endmodule

// ----- tb/top_k_quality_buffer_test.sv -----
// self-checking testbench for the top-k quality buffer: directed table, then random phases
`timescale 1ns / 1ps

module top_k_quality_buffer_test;
   import tkqb_pkg::*;

   localparam int SLOTS           = MAX_ENTRIES_DEF;
   localparam int SETTLE_CYCLES   = MAX_ENTRIES_DEF + 6;
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int LONG_HOLD       = 400;
   localparam int PHASES          = 10;
   localparam int ITEMS_PER_PHASE = 123;
   localparam int DIRECTED_ROWS   = 24;

   typedef struct packed {
      logic                     func;
      logic [BOX_BITS-1:0]      box_width;
      logic [BOX_BITS-1:0]      box_height;
      logic [PORT_TAG_BITS-1:0] frame_tag;
   } request_type;

   typedef struct packed {
      logic                     entry_valid;
      logic [PORT_TAG_BITS-1:0] entry_tag;
      logic [QUALITY_BITS-1:0]  entry_quality;
      logic                     offer_stored;
      logic [COUNT_BITS-1:0]    held_count;
   } result_type;

   typedef enum logic {ROW_REQUEST, ROW_KEEP_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [KEEP_BITS-1:0] keep;
      request_type          req;
      logic                 typed;
      result_type           want;
   } stim_row_type;

   typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   // dut ports
   logic                     clock;
   logic                     reset          = 1'b1;
   logic                     req_valid      = 1'b0;
   logic                     req_stall;
   logic                     req_func       = FUNC_OFFER;
   logic [BOX_BITS-1:0]      req_box_width  = '0;
   logic [BOX_BITS-1:0]      req_box_height = '0;
   logic [PORT_TAG_BITS-1:0] req_frame_tag  = '0;
   logic                     rsp_valid;
   logic                     rsp_stall      = 1'b0;
   logic                     rsp_entry_valid;
   logic [PORT_TAG_BITS-1:0] rsp_entry_tag;
   logic [QUALITY_BITS-1:0]  rsp_entry_quality;
   logic                     rsp_offer_stored;
   logic [COUNT_BITS-1:0]    rsp_held_count;
   logic                     csr_write_en   = 1'b0;
   logic [KEEP_BITS-1:0]     csr_write_data = '0;

   // predicted buffer contents and register
   logic [QUALITY_BITS-1:0]  slot_q [SLOTS];
   logic [PORT_TAG_BITS-1:0] slot_t [SLOTS];
   int                       held_n     = 0;
   logic [QUALITY_BITS-1:0]  lowest_q   = '0;
   logic [KEEP_BITS-1:0]     keep_reg   = KEEP_RESET;

   result_type    pending_results [$];
   int            error_count   = 0;
   int            quiet_cycles  = 0;
   int            hold_requests = 0;
   int            hold_seen     = 0;
   int            hold_left     = 0;
   idle_mode_type idle_mode     = IDLE_NONE;

   top_k_quality_buffer DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_box_width    (req_box_width),
      .req_box_height   (req_box_height),
      .req_frame_tag    (req_frame_tag),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_entry_valid  (rsp_entry_valid),
      .rsp_entry_tag    (rsp_entry_tag),
      .rsp_entry_quality(rsp_entry_quality),
      .rsp_offer_stored (rsp_offer_stored),
      .rsp_held_count   (rsp_held_count),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data)
   );

   // directed rows: typed results only for reset, extremes and empty takes
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_REQUEST, 5'd0, '{FUNC_TAKE, 12'd0, 12'd0, 32'd0}, 1'b1,
        '{1'b0, 32'd0, 24'd0, 1'b0, 5'd0}},
      '{ROW_REQUEST, 5'd0, '{FUNC_OFFER, 12'd0, 12'd0, 32'd0}, 1'b1,
        '{1'b0, 32'd0, 24'd0, 1'b1, 5'd1}},
      '{ROW_REQUEST, 5'd0, '{FUNC_OFFER, 12'd4095, 12'd4095, 32'hFFFF_FFFF}, 1'b1,
        '{1'b0, 32'd0, 24'd0, 1'b1, 5'd2}},
      '{ROW_REQUEST, 5'd0, '{FUNC_OFFER, 12'd1, 12'd1, 32'h5555_5555}, 1'b1,
        '{1'b0, 32'd0, 24'd0, 1'b1, 5'd3}},
      '{ROW_REQUEST, 5'd0, '{FUNC_OFFER, 12'd2048, 12'd1, 32'hAAAA_AAAA}, 1'b1,
        '{1'b0, 32'd0, 24'd0, 1'b1, 5'd4}},
      '{ROW_REQUEST, 5'd0, '{FUNC_OFFER, 12'd0, 12'd256, 32'd1}, 1'b0, '0},
      '{ROW_REQUEST, 5'd0, '{FUNC_OFFER, 12'd3, 12'd3, 32'd2}, 1'b0, '0},
      '{ROW_REQUEST, 5'd0, '{FUNC_OFFER, 12'd0, 12'd5, 32'd3}, 1'b0, '0},
      '{ROW_REQUEST, 5'd0, '{FUNC_OFFER, 12'd1, 12'd1, 32'd4}, 1'b0, '0},
      '{ROW_REQUEST, 5'd0, '{FUNC_OFFER, 12'd1, 12'd2, 32'd5}, 1'b0, '0},
      '{ROW_REQUEST, 5'd0, '{FUNC_TAKE, 12'd0, 12'd0, 32'd0}, 1'b1,
        '{1'b1, 32'hFFFF_FFFF, 24'hFF_E001, 1'b0, 5'd3}},
      '{ROW_REQUEST, 5'd0, '{FUNC_OFFER, 12'd2, 12'd1, 32'd6}, 1'b0, '0},
      '{ROW_REQUEST, 5'd0, '{FUNC_OFFER, 12'd1, 12'd2, 32'd7}, 1'b0, '0},
      '{ROW_REQUEST, 5'd0, '{FUNC_TAKE, 12'd0, 12'd0, 32'd0}, 1'b0, '0},
      '{ROW_REQUEST, 5'd0, '{FUNC_TAKE, 12'd0, 12'd0, 32'd0}, 1'b0, '0},
      '{ROW_REQUEST, 5'd0, '{FUNC_TAKE, 12'd0, 12'd0, 32'd0}, 1'b0, '0},
      '{ROW_REQUEST, 5'd0, '{FUNC_TAKE, 12'd0, 12'd0, 32'd0}, 1'b0, '0},
      '{ROW_REQUEST, 5'd0, '{FUNC_TAKE, 12'd0, 12'd0, 32'd0}, 1'b1,
        '{1'b0, 32'd0, 24'd0, 1'b0, 5'd0}},
      '{ROW_KEEP_WRITE, 5'd0, '0, 1'b0, '0},
      '{ROW_REQUEST, 5'd0, '{FUNC_OFFER, 12'd1, 12'd5, 32'd8}, 1'b0, '0},
      '{ROW_REQUEST, 5'd0, '{FUNC_OFFER, 12'd3, 12'd1, 32'd9}, 1'b0, '0},
      '{ROW_REQUEST, 5'd0, '{FUNC_OFFER, 12'd7, 12'd1, 32'd10}, 1'b0, '0},
      '{ROW_KEEP_WRITE, 5'd31, '0, 1'b0, '0},
      '{ROW_REQUEST, 5'd0, '{FUNC_TAKE, 12'd0, 12'd0, 32'd0}, 1'b0, '0}
   };

   logic [KEEP_BITS-1:0] phase_keep [PHASES] = '{
      5'd31, 5'd1, 5'd16, 5'd0, 5'd7, 5'd2, 5'd12, 5'd4, 5'd17, 5'd3
   };

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // first held position with the lowest quality
   function automatic int lowest_slot();
      int pos;
      pos = 0;
      for (int i = 1; i < held_n; i++)
         if (slot_q[i] < slot_q[pos]) pos = i;
      return pos;
   endfunction

   // applies one request to the predicted buffer and returns its response
   function automatic result_type buffer_outcome(request_type r);
      result_type              res;
      logic [QUALITY_BITS-1:0] q;
      int                      keep_eff;
      int                      pos;
      res = '0;
      keep_eff = (keep_reg == 0) ? 1 : ((keep_reg > SLOTS) ? SLOTS : int'(keep_reg));
      if (r.func == FUNC_OFFER) begin
         q = r.box_width * r.box_height;
         if (held_n < keep_eff) begin
            // room left: append
            slot_q[held_n] = q;
            slot_t[held_n] = r.frame_tag;
            held_n++;
            res.offer_stored = 1'b1;
         end else if (q >= lowest_q) begin
            // replace the first minimum when strictly lower, then rescan
            pos = lowest_slot();
            if (slot_q[pos] < q) begin
               slot_q[pos] = q;
               slot_t[pos] = r.frame_tag;
               res.offer_stored = 1'b1;
            end
            lowest_q = slot_q[lowest_slot()];
         end
      end else if (held_n > 0) begin
         // take the first maximum and close the gap
         pos = 0;
         for (int i = 1; i < held_n; i++)
            if (slot_q[i] > slot_q[pos]) pos = i;
         res.entry_valid   = 1'b1;
         res.entry_tag     = slot_t[pos];
         res.entry_quality = slot_q[pos];
         for (int i = pos; i + 1 < held_n; i++) begin
            slot_q[i] = slot_q[i + 1];
            slot_t[i] = slot_t[i + 1];
         end
         held_n--;
      end
      res.held_count = COUNT_BITS'(held_n);
      return res;
   endfunction

   function automatic int idle_pct(bit receiver_side);
      case (idle_mode)
         IDLE_SENDER:   return receiver_side ? 0 : 58;
         IDLE_RECEIVER: return receiver_side ? 58 : 0;
         IDLE_BOTH:     return 19;
         default:       return 0;
      endcase
   endfunction

   // random request: sizes lean small so ties and equal qualities show up
   function automatic request_type random_request(int offer_pct);
      request_type r;
      int          size_class;
      r.func = ($urandom_range(99) < offer_pct) ? FUNC_OFFER : FUNC_TAKE;
      size_class = $urandom_range(9);
      if (size_class < 4) begin
         r.box_width  = BOX_BITS'($urandom_range(3));
         r.box_height = BOX_BITS'($urandom_range(3));
      end else if (size_class < 8) begin
         r.box_width  = BOX_BITS'($urandom_range(4095));
         r.box_height = BOX_BITS'($urandom_range(4095));
      end else if (size_class == 8) begin
         r.box_width  = 12'd4095;
         r.box_height = $urandom_range(1) ? 12'd4095 : BOX_BITS'($urandom_range(4095));
      end else begin
         r.box_width  = $urandom_range(1) ? 12'd0 : BOX_BITS'($urandom_range(4095));
         r.box_height = $urandom_range(1) ? 12'd0 : 12'd4095;
      end
      r.frame_tag = $urandom;
      return r;
   endfunction

   // offer one request and wait for it to be taken
   task automatic send_request(request_type r, logic typed, result_type typed_res);
      result_type predicted;
      req_valid      <= 1'b1;
      req_func       <= r.func;
      req_box_width  <= r.box_width;
      req_box_height <= r.box_height;
      req_frame_tag  <= r.frame_tag;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predicted = buffer_outcome(r);
      pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
   endtask

   // random sender gap after an accepted request
   task automatic sender_gap();
      int gap;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < idle_pct(1'b0)) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop sending, wait for every response, then let the block settle
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_keep(logic [KEEP_BITS-1:0] value);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      keep_reg = value;
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // response side: check accepted responses, then decide the next stall
   always @(posedge clock) begin : response_check
      result_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: response with no request pending", $time);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("entry_valid", 32'(want.entry_valid), 32'(rsp_entry_valid));
            check_field("entry_tag", want.entry_tag, rsp_entry_tag);
            check_field("entry_quality", 32'(want.entry_quality), 32'(rsp_entry_quality));
            check_field("offer_stored", 32'(want.offer_stored), 32'(rsp_offer_stored));
            check_field("held_count", 32'(want.held_count), 32'(rsp_held_count));
         end
      end
      if (hold_requests != hold_seen) begin
         hold_seen = hold_requests;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < idle_pct(1'b1));
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (directed_rows[i].kind == ROW_KEEP_WRITE) begin
            drain_responses();
            write_keep(directed_rows[i].keep);
         end else begin
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
         end
      end

      // random phases, each with its own keep count and idling pattern
      for (int p = 0; p < PHASES; p++) begin
         drain_responses();
         write_keep(phase_keep[p]);
         idle_mode = idle_mode_type'(p % 4);
         // long receiver hold-off while requests keep coming
         if (p == 0) hold_requests++;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_request(random_request((p % 2 == 0) ? 75 : 40), 1'b0, '0);
            sender_gap();
         end
      end

      drain_responses();
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
